/* sv/scl_pkg.sv */
// Shared constants, keyword table and helpers for the serial command line parser.
`timescale 1ns / 1ps

package scl_pkg;

    localparam int LINE_LEN_DEF = 128;
    localparam int WORD_LEN_DEF = 16;

    localparam int NUM_KEYS = 10;
    localparam int KEY_MAX  = 6;

    localparam logic [7:0] CH_CR   = 8'd13;
    localparam logic [7:0] CH_BS   = 8'd8;
    localparam logic [7:0] CH_SP   = 8'd32;
    localparam logic [7:0] CH_NUL  = 8'd0;
    localparam logic [7:0] CH_ZERO = 8'd48;

    localparam logic [3:0] CODE_NO_MATCH = 4'd10;

    typedef logic [NUM_KEYS-1:0] key_mask_t;

    function automatic logic [2:0] key_len(input logic [3:0] k);
        logic [2:0] n;
        case (k)
            4'd0:    n = 3'd4;
            4'd1:    n = 3'd2;
            4'd2:    n = 3'd5;
            4'd3:    n = 3'd6;
            4'd4:    n = 3'd5;
            4'd5:    n = 3'd5;
            4'd6:    n = 3'd6;
            4'd7:    n = 3'd5;
            4'd8:    n = 3'd6;
            4'd9:    n = 3'd4;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] key_char(input logic [3:0] k, input logic [2:0] pos);
        logic [63:0] t;
        logic [2:0]  sel;
        case (k)
            4'd0:    t = 64'("help");
            4'd1:    t = 64'("cb");
            4'd2:    t = 64'("spkon");
            4'd3:    t = 64'("spkoff");
            4'd4:    t = 64'("sound");
            4'd5:    t = 64'("dtime");
            4'd6:    t = 64'("reboot");
            4'd7:    t = 64'("ledon");
            4'd8:    t = 64'("ledoff");
            4'd9:    t = 64'("exit");
            default: t = 64'd0;
        endcase
        sel = key_len(k) - 3'd1 - pos;
        return t[8*sel +: 8];
    endfunction

endpackage

/* sv/scl_ram.sv */
// Generic single-port synchronous RAM with registered read.
`timescale 1ns / 1ps

module scl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* sv/serial_command_line_parser_top.sv */
// Top level of the serial command line parser: echo, line buffer and command scan.
//
// Usage: one received byte enters per input request (in_valid high, in_stall low).
// Each byte returns one or more result requests on the output channel; last marks
// the final one. An ordinary byte is stored and echoed (one result). A backspace
// gives three echoes (backspace, space, backspace) and drops the last stored byte.
// A carriage return, or any non-backspace byte when the line holds LINE_LEN-1 bytes,
// gives its echo and then a command result with command_code and argument, and
// empties the line.
// Timing: an accepted ordinary byte waits in the ECHO state until the output
// register is free; the input is taken again in the cycle after the echo is
// loaded into the output register. A backspace passes the states BS0, BS1 and
// BS2, one echo each. A line end scans the stored bytes through the line buffer's
// one read port, each byte via states RD and PROC, and stops early after word two.
// The block takes one byte at a time; in_stall stays high until its last result
// is loaded into the output register.
// Reset empties the line and clears the output valid flag. When out_stall is high
// the output register holds its request; the scan runs on and waits to load its
// command result.
`timescale 1ns / 1ps

module serial_command_line_parser_top #(
    parameter int LINE_LEN = scl_pkg::LINE_LEN_DEF,
    parameter int WORD_LEN = scl_pkg::WORD_LEN_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               is_command,
    output logic [7:0]         echo_byte,
    output logic [3:0]         command_code,
    output logic signed [31:0] argument,
    output logic               last
);

    import scl_pkg::*;

    localparam int AW = $clog2(LINE_LEN);
    localparam int TW = $clog2(WORD_LEN);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ECHO = 4'd1;
    localparam logic [3:0] S_BS0  = 4'd2;
    localparam logic [3:0] S_BS1  = 4'd3;
    localparam logic [3:0] S_BS2  = 4'd4;
    localparam logic [3:0] S_EOL  = 4'd5;
    localparam logic [3:0] S_RD   = 4'd6;
    localparam logic [3:0] S_PROC = 4'd7;
    localparam logic [3:0] S_CMD  = 4'd8;

    localparam logic [1:0] PH_WORD1 = 2'd0;
    localparam logic [1:0] PH_SKIP  = 2'd1;
    localparam logic [1:0] PH_WORD2 = 2'd2;

    logic [3:0]    state_reg, state_next;
    logic [1:0]    phase_reg, phase_next;
    logic [AW-1:0] fill_reg, fill_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] wend_reg, wend_next;
    logic [TW-1:0] taken_reg, taken_next;
    logic [31:0]   sum_reg, sum_next;
    key_mask_t     mask_reg, mask_next;
    logic [7:0]    byte_reg, byte_next;

    logic          ov_reg, ov_next;
    logic          oc_reg, oc_next;
    logic [7:0]    oe_reg, oe_next;
    logic [3:0]    ocode_reg, ocode_next;
    logic [31:0]   oarg_reg, oarg_next;
    logic          olast_reg, olast_next;

    logic          accept;
    logic          out_free;
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_rdata;
    logic [3:0]    match_code;
    key_mask_t     mask_step;
    logic [31:0]   sum_step;

    scl_ram #(
        .WIDTH (8),
        .DEPTH (LINE_LEN)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (rx_byte),
        .rdata (ram_rdata)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !ov_reg || !out_stall;

    assign out_valid    = ov_reg;
    assign is_command   = oc_reg;
    assign echo_byte    = oe_reg;
    assign command_code = ocode_reg;
    assign argument     = oarg_reg;
    assign last         = olast_reg;

    assign ram_we   = accept && rx_byte != CH_BS && rx_byte != CH_CR
                      && fill_reg != AW'(LINE_LEN - 1);
    assign ram_addr = (state_reg == S_IDLE) ? fill_reg : idx_reg;

    assign sum_step = (sum_reg << 3) + (sum_reg << 1) + {24'd0, ram_rdata} - {24'd0, CH_ZERO};

    always_comb
    begin
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            mask_step[k] = mask_reg[k]
                && (32'(idx_reg) < 32'(key_len(4'(k))))
                && (ram_rdata == key_char(4'(k), 3'(idx_reg)));
        end
    end

    always_comb
    begin
        match_code = CODE_NO_MATCH;
        for (int k = NUM_KEYS - 1; k >= 0; k--)
        begin
            if (mask_reg[k] && 32'(wend_reg) == 32'(key_len(4'(k))))
            begin
                match_code = 4'(k);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        fill_next  = fill_reg;
        idx_next   = idx_reg;
        wend_next  = wend_reg;
        taken_next = taken_reg;
        sum_next   = sum_reg;
        mask_next  = mask_reg;
        byte_next  = byte_reg;
        ov_next    = ov_reg && out_stall;
        oc_next    = oc_reg;
        oe_next    = oe_reg;
        ocode_next = ocode_reg;
        oarg_next  = oarg_reg;
        olast_next = olast_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    byte_next = rx_byte;
                    if (rx_byte == CH_BS)
                    begin
                        state_next = S_BS0;
                        if (fill_reg != '0)
                        begin
                            fill_next = fill_reg - AW'(1);
                        end
                    end
                    else if (rx_byte == CH_CR || fill_reg == AW'(LINE_LEN - 1))
                    begin
                        state_next = S_EOL;
                    end
                    else
                    begin
                        fill_next  = fill_reg + AW'(1);
                        state_next = S_ECHO;
                    end
                end
            end
            S_ECHO, S_BS0, S_BS1, S_BS2, S_EOL:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    oc_next    = 1'b0;
                    ocode_next = 4'd0;
                    oarg_next  = 32'd0;
                    olast_next = (state_reg == S_ECHO) || (state_reg == S_BS2);
                    case (state_reg)
                        S_BS1:   oe_next = CH_SP;
                        S_BS0,
                        S_BS2:   oe_next = CH_BS;
                        default: oe_next = byte_reg;
                    endcase
                    case (state_reg)
                        S_BS0:   state_next = S_BS1;
                        S_BS1:   state_next = S_BS2;
                        S_EOL:
                        begin
                            state_next = S_RD;
                            phase_next = PH_WORD1;
                            idx_next   = '0;
                            wend_next  = '0;
                            taken_next = '0;
                            sum_next   = 32'd0;
                            mask_next  = '1;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_RD:
            begin
                if (idx_reg == fill_reg)
                begin
                    if (phase_reg == PH_WORD1)
                    begin
                        wend_next = idx_reg;
                    end
                    state_next = S_CMD;
                end
                else
                begin
                    state_next = S_PROC;
                end
            end
            S_PROC:
            begin
                state_next = S_RD;
                idx_next   = idx_reg + AW'(1);
                if (ram_rdata == CH_NUL)
                begin
                    if (phase_reg == PH_WORD1)
                    begin
                        wend_next = idx_reg;
                    end
                    state_next = S_CMD;
                end
                else
                begin
                    case (phase_reg)
                        PH_WORD1:
                        begin
                            if (ram_rdata == CH_SP)
                            begin
                                wend_next  = idx_reg;
                                phase_next = PH_SKIP;
                            end
                            else
                            begin
                                mask_next = mask_step;
                            end
                        end
                        PH_SKIP:
                        begin
                            if (ram_rdata != CH_SP)
                            begin
                                sum_next   = sum_step;
                                taken_next = TW'(1);
                                phase_next = PH_WORD2;
                            end
                        end
                        default:
                        begin
                            if (ram_rdata == CH_SP || taken_reg == TW'(WORD_LEN - 1))
                            begin
                                state_next = S_CMD;
                            end
                            else
                            begin
                                sum_next   = sum_step;
                                taken_next = taken_reg + TW'(1);
                            end
                        end
                    endcase
                end
            end
            S_CMD:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    oc_next    = 1'b1;
                    oe_next    = 8'd0;
                    ocode_next = match_code;
                    oarg_next  = sum_reg;
                    olast_next = 1'b1;
                    fill_next  = '0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        phase_reg <= phase_next;
        idx_reg   <= idx_next;
        wend_reg  <= wend_next;
        taken_reg <= taken_next;
        sum_reg   <= sum_next;
        mask_reg  <= mask_next;
        byte_reg  <= byte_next;
        oc_reg    <= oc_next;
        oe_reg    <= oe_next;
        ocode_reg <= ocode_next;
        oarg_reg  <= oarg_next;
        olast_reg <= olast_next;
    end

endmodule
